>>> rtl/fuzzy_membership_five_sets_top_assert.svh
// assertion helpers for the fuzzifier, clocked on clk_i, off while rst_ni is low
`ifndef FUZZY_MEMBERSHIP_FIVE_SETS_TOP_ASSERT_SVH
`define FUZZY_MEMBERSHIP_FIVE_SETS_TOP_ASSERT_SVH

// same-cycle implication
`define FMF_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fmf check failed");

// next-cycle implication
`define FMF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fmf check failed");

`endif

>>> rtl/fmf_pkg.sv
`timescale 1ns / 1ps
package fmf_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int BP_BITS     = 16;
  localparam int DIST_BITS   = BP_BITS;
  localparam int QUO_BITS    = 15;
  localparam int DIV_CELLS   = QUO_BITS;
  localparam int DEG_BITS    = 16;
  localparam int IDX_BITS    = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 48;

  localparam logic [DEG_BITS-1:0] ONE_Q15 = DEG_BITS'(32768);

  // set index codes
  localparam logic [IDX_BITS-1:0] SET_NG = 3'd0;
  localparam logic [IDX_BITS-1:0] SET_NP = 3'd1;
  localparam logic [IDX_BITS-1:0] SET_Z  = 3'd2;
  localparam logic [IDX_BITS-1:0] SET_PP = 3'd3;
  localparam logic [IDX_BITS-1:0] SET_PG = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_NG = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NP = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_Z  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PP = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PG = 3'd4;

  typedef struct packed {
    logic [31:0] ng;
    logic [47:0] np;
    logic [47:0] z;
    logic [47:0] pp;
    logic [31:0] pg;
  } fmf_cfg_t;

  // one item on its way through the divider row
  typedef struct packed {
    logic                 full;
    logic                 zero;
    logic [DIST_BITS-1:0] rem;
    logic [DIST_BITS-1:0] den;
    logic [QUO_BITS-1:0]  quo;
  } fmf_stage_t;

endpackage

>>> rtl/fmf_if.sv
`timescale 1ns / 1ps
interface fmf_in_if;
  import fmf_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [IDX_BITS-1:0]           set_index;

  modport source (output valid, output sample, output set_index, input ready);
  modport sink   (input valid, input sample, input set_index, output ready);
endinterface

interface fmf_out_if;
  import fmf_pkg::*;
  logic                valid;
  logic                ready;
  logic [DEG_BITS-1:0] degree;

  modport source (output valid, output degree, input ready);
  modport sink   (input valid, input degree, output ready);
endinterface

>>> rtl/fuzzy_membership_five_sets_top.sv
`timescale 1ns / 1ps
// channel   dir  payload                         beat taken when
// in_if     in   sample[15:0] s, set_index[2:0]  valid & ready
// out_if    out  degree[15:0]                    valid & ready
// cfg       in   cfg_idx_i, cfg_data_i[47:0]     cfg_we_i
//
// one beat per cycle in and out unless out_if stalls; stages: edge select,
// 15 divider cells (one quotient bit each), output register
// every stage has its own valid, so bubbles close up while out_if is stalled
// reset clears the valid bits and all breakpoint registers to zero
module fuzzy_membership_five_sets_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  fmf_in_if.sink                            in_if,
  fmf_out_if.source                         out_if,
  input  logic                              cfg_we_i,
  input  logic [fmf_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [fmf_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);
  import fmf_pkg::*;

  fmf_cfg_t       cfg_q;
  logic           stage_valid [DIV_CELLS+1];
  logic           stage_ready [DIV_CELLS+1];
  fmf_stage_t     stage_data  [DIV_CELLS+1];
  logic           out_valid_q;
  logic [DEG_BITS-1:0] degree_q, degree_d;
  fmf_stage_t     last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NG:  cfg_q.ng <= cfg_data_i[31:0];
        CFG_NP:  cfg_q.np <= cfg_data_i[47:0];
        CFG_Z:   cfg_q.z  <= cfg_data_i[47:0];
        CFG_PP:  cfg_q.pp <= cfg_data_i[47:0];
        CFG_PG:  cfg_q.pg <= cfg_data_i[31:0];
        default: cfg_q    <= cfg_q;
      endcase
    end
  end

  fmf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .valid_i     (in_if.valid),
    .ready_o     (in_if.ready),
    .sample_i    (in_if.sample),
    .set_index_i (in_if.set_index),
    .valid_o     (stage_valid[0]),
    .ready_i     (stage_ready[0]),
    .data_o      (stage_data[0])
  );

  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_cell
    fmf_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[k]),
      .ready_o (stage_ready[k]),
      .data_i  (stage_data[k]),
      .valid_o (stage_valid[k+1]),
      .ready_i (stage_ready[k+1]),
      .data_o  (stage_data[k+1])
    );
  end

  assign last = stage_data[DIV_CELLS];
  assign stage_ready[DIV_CELLS] = !out_valid_q || out_if.ready;

  always_comb begin
    if (last.full) begin
      degree_d = ONE_Q15;
    end else if (last.zero) begin
      degree_d = '0;
    end else begin
      degree_d = {{(DEG_BITS-QUO_BITS){1'b0}}, last.quo};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stage_ready[DIV_CELLS]) begin
      out_valid_q <= stage_valid[DIV_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_ready[DIV_CELLS] && stage_valid[DIV_CELLS]) begin
      degree_q <= degree_d;
    end
  end

  assign out_if.valid  = out_valid_q;
  assign out_if.degree = degree_q;

`include "fuzzy_membership_five_sets_top_assert.svh"

  `FMF_ASSERT(a_degree_range, out_if.valid, out_if.degree <= ONE_Q15)
  `FMF_ASSERT_NEXT(a_unused_set_zero,
                   in_if.valid && in_if.ready && in_if.set_index > SET_PG,
                   stage_valid[0] && stage_data[0].zero && !stage_data[0].full)
  `FMF_ASSERT(a_flags_exclusive, stage_valid[0], !(stage_data[0].full && stage_data[0].zero))

endmodule

>>> rtl/fmf_front.sv
`timescale 1ns / 1ps
module fmf_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  fmf_pkg::fmf_cfg_t                     cfg_i,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic signed [fmf_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic [fmf_pkg::IDX_BITS-1:0]          set_index_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output fmf_pkg::fmf_stage_t                   data_o
);
  import fmf_pkg::*;

  function automatic logic signed [BP_BITS:0] gap(logic signed [BP_BITS-1:0] a,
                                                  logic signed [BP_BITS-1:0] b);
    gap = {a[BP_BITS-1], a} - {b[BP_BITS-1], b};
  endfunction

  logic signed [BP_BITS-1:0] x;
  logic [47:0]               tri_pts;
  logic signed [BP_BITS-1:0] bl, bp, br;
  logic signed [BP_BITS-1:0] na, nb, da, db;
  logic signed [BP_BITS:0]   num, den;
  logic                      slope, sat;
  logic                      valid_q;
  fmf_stage_t                data_q, data_d;

  assign x = BP_BITS'(sample_i);

  always_comb begin
    case (set_index_i)
      SET_NP:  tri_pts = cfg_i.np;
      SET_Z:   tri_pts = cfg_i.z;
      default: tri_pts = cfg_i.pp;
    endcase
    bl = tri_pts[15:0];
    bp = tri_pts[31:16];
    br = tri_pts[47:32];
  end

  // pick the sloped edge: degree = (na - nb) / (da - db)
  always_comb begin
    slope = 1'b0;
    sat   = 1'b0;
    na    = '0;
    nb    = '0;
    da    = '0;
    db    = '0;
    case (set_index_i)
      SET_NG: begin
        if (x < $signed(cfg_i.ng[15:0])) begin
          sat = 1'b1;
        end else if (x <= $signed(cfg_i.ng[31:16])) begin
          slope = 1'b1;
          na = cfg_i.ng[31:16];
          nb = x;
          da = cfg_i.ng[31:16];
          db = cfg_i.ng[15:0];
        end
      end
      SET_NP, SET_Z, SET_PP: begin
        if (x >= bl && x < bp) begin
          slope = 1'b1;
          na = x;
          nb = bl;
          da = bp;
          db = bl;
        end else if (x >= bp && x <= br) begin
          slope = 1'b1;
          na = br;
          nb = x;
          da = br;
          db = bp;
        end
      end
      SET_PG: begin
        if (x >= $signed(cfg_i.pg[15:0]) && x <= $signed(cfg_i.pg[31:16])) begin
          slope = 1'b1;
          na = x;
          nb = cfg_i.pg[15:0];
          da = cfg_i.pg[31:16];
          db = cfg_i.pg[15:0];
        end else if (x > $signed(cfg_i.pg[31:16])) begin
          sat = 1'b1;
        end
      end
      default: begin
        slope = 1'b0;
      end
    endcase
  end

  always_comb begin
    num = gap(na, nb);
    den = gap(da, db);
    // num never exceeds den on a slope; equal (also zero width) means one
    data_d.full = sat || (slope && (num == den));
    data_d.zero = !sat && !slope;
    data_d.rem  = num[DIST_BITS-1:0];
    data_d.den  = den[DIST_BITS-1:0];
    data_d.quo  = '0;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/fmf_div_cell.sv
`timescale 1ns / 1ps
module fmf_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  fmf_pkg::fmf_stage_t data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output fmf_pkg::fmf_stage_t data_o
);
  import fmf_pkg::*;

  logic [DIST_BITS:0] rem2;
  logic               ge;
  logic               valid_q;
  fmf_stage_t         data_q, data_d;

  // one restoring step: one quotient bit per cell
  always_comb begin
    rem2   = {data_i.rem, 1'b0};
    ge     = rem2 >= {1'b0, data_i.den};
    data_d = data_i;
    if (ge) begin
      data_d.rem = DIST_BITS'(rem2 - {1'b0, data_i.den});
    end else begin
      data_d.rem = rem2[DIST_BITS-1:0];
    end
    data_d.quo = {data_i.quo[QUO_BITS-2:0], ge};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
